// File: design/ntt_pkg.sv
`default_nettype none
package ntt_pkg;

    localparam int DATA_W        = 30;
    localparam int KIND_W        = 2;
    localparam int IDX_W         = 10;
    localparam int LOGSZ_W       = 4;
    localparam int DEF_LOG_DEPTH = 10;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_XFORM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [DATA_W-1:0] MODULUS  = 30'd998244353;
    localparam logic [DATA_W-1:0] MOD_M1   = MODULUS - 30'd1;
    localparam logic [DATA_W-1:0] MOD_M2   = MODULUS - 30'd2;
    localparam logic [DATA_W-1:0] ROOT     = 30'd3;
    localparam logic [DATA_W-1:0] ROOT_INV = 30'd332748118;

endpackage
`default_nettype wire

// File: design/ntt_mulmod.sv
`default_nettype none
// Bit-serial modular multiplier, MSB of b first, one bit per cycle.
module ntt_mulmod (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [ntt_pkg::DATA_W-1:0] a,
    input  wire logic [ntt_pkg::DATA_W-1:0] b,
    output logic                           done,
    output logic [ntt_pkg::DATA_W-1:0]     result
);
    import ntt_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [DATA_W+1:0] sum;
    logic [DATA_W+1:0] red;

    always_comb
    begin
        // acc, a < P so 2*acc + a < 3P
        sum = {1'b0, acc_reg, 1'b0}
            + {2'b00, (b_reg[DATA_W-1] ? a_reg : {DATA_W{1'b0}})};
        if (sum >= {1'b0, MODULUS, 1'b0})
            red = sum - {1'b0, MODULUS, 1'b0};
        else if (sum >= {2'b00, MODULUS})
            red = sum - {2'b00, MODULUS};
        else
            red = sum;
    end

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = '0;
            a_next   = a;
            b_next   = b;
            cnt_next = CNT_W'(DATA_W - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next = red[DATA_W-1:0];
            b_next   = {b_reg[DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule
`default_nettype wire

// File: design/number_theoretic_transform.sv
`default_nettype none
// Radix-2 NTT modulo 998244353 (primitive root 3) over an in-place coefficient
// memory of 2**LOG_DEPTH residues. Requests arrive on the s_ stream; tuser
// carries the kind: write stores one coefficient (values >= P are reduced),
// read returns one, transform bit-reverses the first 2**log_size entries
// (log_size saturates at LOG_DEPTH), runs Cooley-Tukey butterflies and, for
// the inverse direction, scales by 1/size. Every request yields exactly one
// response on the m_ stream echoing the kind; read_value is zero except on
// reads. Kind 3 changes nothing. A write or an unknown kind is answered from
// idle, a read by way of S_RD. A transform runs the bit reversal, then per
// stage the twiddle power and the butterflies, then for the inverse the power
// that gives 1/size and the scaling; every product is made on the one shared
// bit-serial modular multiplier. s_tready is low while a request is in work or
// its response cannot be taken. Entries read before they are written return
// undefined data.
module number_theoretic_transform #(
    parameter int LOG_DEPTH = ntt_pkg::DEF_LOG_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [9:0] index, [39:10] value, [40] inverse, [44:41] log_size, [47:45] zero
    input  wire logic [47:0] s_tdata,
    // [1:0] kind
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [29:0] read_value, [31:30] zero
    output logic [31:0]      m_tdata,
    // [1:0] done_kind
    output logic [1:0]       m_tuser
);
    import ntt_pkg::*;

    localparam int AW    = LOG_DEPTH;
    localparam int CW    = LOG_DEPTH + 1;
    localparam int LGW   = $clog2(LOG_DEPTH + 1);
    localparam int DEPTH = 1 << LOG_DEPTH;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_BR_CHK, S_BR_RD2, S_BR_WR1, S_BR_WR2, S_ST_CHK,
        S_POW, S_POW_MA, S_POW_MB, S_BF_RD1, S_BF_RD2, S_BF_MUL0, S_BF_MUL,
        S_BF_WR1, S_BF_WR2, S_BF_TW, S_SC_RD, S_SC_MUL, S_SC_WAIT, S_DONE
    } state_t;

    // Request fields
    logic [KIND_W-1:0]  in_kind;
    logic [IDX_W-1:0]   in_index;
    logic [DATA_W-1:0]  in_value;
    logic               in_inverse;
    logic [LOGSZ_W-1:0] in_log_size;
    logic [IDX_W+AW-1:0] idx_ext;
    logic [AW-1:0]      in_addr;
    logic [DATA_W-1:0]  in_value_red;
    logic [LGW-1:0]     in_lg;
    logic               accept;

    assign in_kind     = s_tuser;
    assign in_index    = s_tdata[9:0];
    assign in_value    = s_tdata[39:10];
    assign in_inverse  = s_tdata[40];
    assign in_log_size = s_tdata[44:41];
    assign idx_ext     = {{AW{1'b0}}, in_index};
    assign in_addr     = idx_ext[AW-1:0];
    assign in_value_red = (in_value >= MODULUS) ? (in_value - MODULUS) : in_value;
    assign in_lg = ({1'b0, in_log_size} > (LOGSZ_W+1)'(LOG_DEPTH)) ?
                   LGW'(LOG_DEPTH) : LGW'(in_log_size);

    state_t            state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic [KIND_W-1:0] out_kind_reg, out_kind_next;
    logic [LGW-1:0]    lg_reg, lg_next;
    logic              inv_reg, inv_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     grp_reg, grp_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     half_reg, half_next;
    logic [LGW-1:0]    stage_reg, stage_next;
    logic [DATA_W-1:0] u_reg, u_next;
    logic [DATA_W-1:0] t_reg, t_next;
    logic [DATA_W-1:0] w_reg, w_next;
    logic [DATA_W-1:0] step_reg, step_next;
    logic [DATA_W-1:0] scale_reg, scale_next;
    logic [DATA_W-1:0] pbase_reg, pbase_next;
    logic [DATA_W-1:0] pacc_reg, pacc_next;
    logic [DATA_W-1:0] pexp_reg, pexp_next;
    logic              pscale_reg, pscale_next;

    // Coefficient memory
    logic [DATA_W-1:0] mem [DEPTH];
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // Shared multiplier
    logic              mul_start;
    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic              mul_done;
    logic [DATA_W-1:0] mul_res;

    ntt_mulmod u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    // Loop helpers
    logic [CW-1:0]     n_w;
    logic [AW-1:0]     rev_full;
    logic [CW-1:0]     rev_w;
    logic [LGW-1:0]    rev_shamt;
    logic [CW-1:0]     j_w;
    logic [CW-1:0]     jh_w;
    logic [CW-1:0]     grp_step;
    logic [DATA_W:0]   bf_sum;
    logic [DATA_W-1:0] bf_add;
    logic [DATA_W-1:0] bf_sub;

    assign n_w = CW'(1) << lg_reg;

    always_comb
    begin
        for (int b = 0; b < AW; b++)
            rev_full[b] = i_reg[AW-1-b];
    end

    assign rev_shamt = LGW'(AW) - lg_reg;
    assign rev_w     = {1'b0, rev_full} >> rev_shamt;
    assign j_w       = grp_reg + k_reg;
    assign jh_w      = j_w + half_reg;
    assign grp_step  = grp_reg + {half_reg[CW-2:0], 1'b0};

    always_comb
    begin
        bf_sum = {1'b0, u_reg} + {1'b0, t_reg};
        bf_add = (bf_sum >= {1'b0, MODULUS}) ? DATA_W'(bf_sum - {1'b0, MODULUS})
                                             : bf_sum[DATA_W-1:0];
        bf_sub = (u_reg >= t_reg) ? (u_reg - t_reg) : (u_reg + (MODULUS - t_reg));
    end

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        lg_next        = lg_reg;
        inv_next       = inv_reg;
        i_next         = i_reg;
        grp_next       = grp_reg;
        k_next         = k_reg;
        half_next      = half_reg;
        stage_next     = stage_reg;
        u_next         = u_reg;
        t_next         = t_reg;
        w_next         = w_reg;
        step_next      = step_reg;
        scale_next     = scale_reg;
        pbase_next     = pbase_reg;
        pacc_next      = pacc_reg;
        pexp_next      = pexp_reg;
        pscale_next    = pscale_reg;
        mem_we         = 1'b0;
        mem_waddr      = i_reg[AW-1:0];
        mem_wdata      = rd_data_reg;
        mem_raddr      = i_reg[AW-1:0];
        mul_start      = 1'b0;
        mul_a          = pbase_reg;
        mul_b          = pbase_reg;

        if (m_tvalid && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                mem_raddr = in_addr;
                if (accept)
                begin
                    case (in_kind)
                        KIND_WRITE:
                        begin
                            mem_we         = 1'b1;
                            mem_waddr      = in_addr;
                            mem_wdata      = in_value_red;
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                            out_kind_next  = in_kind;
                        end
                        KIND_READ:
                            state_next = S_RD;
                        KIND_XFORM:
                        begin
                            lg_next    = in_lg;
                            inv_next   = in_inverse;
                            i_next     = '0;
                            state_next = S_BR_CHK;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                            out_kind_next  = in_kind;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                out_valid_next = 1'b1;
                out_data_next  = rd_data_reg;
                out_kind_next  = KIND_READ;
                state_next     = S_IDLE;
            end
            // bit-reverse permutation
            S_BR_CHK:
            begin
                if (i_reg == n_w)
                begin
                    half_next  = CW'(1);
                    stage_next = LGW'(1);
                    state_next = S_ST_CHK;
                end
                else if (rev_w > i_reg)
                    state_next = S_BR_RD2;
                else
                    i_next = i_reg + 1'b1;
            end
            S_BR_RD2:
            begin
                mem_raddr  = rev_w[AW-1:0];
                u_next     = rd_data_reg;
                state_next = S_BR_WR1;
            end
            S_BR_WR1:
            begin
                mem_we     = 1'b1;
                state_next = S_BR_WR2;
            end
            S_BR_WR2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = rev_w[AW-1:0];
                mem_wdata  = u_reg;
                i_next     = i_reg + 1'b1;
                state_next = S_BR_CHK;
            end
            // per stage: twiddle step = root^((P-1)/len); after the last stage, n^(P-2) for inverse scaling
            S_ST_CHK:
            begin
                pacc_next = DATA_W'(1);
                if (half_reg >= n_w)
                begin
                    pbase_next  = DATA_W'(n_w);
                    pexp_next   = MOD_M2;
                    pscale_next = 1'b1;
                    state_next  = inv_reg ? S_POW : S_DONE;
                end
                else
                begin
                    pbase_next  = inv_reg ? ROOT_INV : ROOT;
                    pexp_next   = MOD_M1 >> stage_reg;
                    pscale_next = 1'b0;
                    state_next  = S_POW;
                end
            end
            // square-and-multiply
            S_POW:
            begin
                if (pexp_reg == '0)
                begin
                    i_next   = '0;
                    grp_next = '0;
                    k_next   = '0;
                    w_next   = DATA_W'(1);
                    if (pscale_reg)
                    begin
                        scale_next = pacc_reg;
                        state_next = S_SC_RD;
                    end
                    else
                    begin
                        step_next  = pacc_reg;
                        state_next = S_BF_RD1;
                    end
                end
                else if (pexp_reg[0])
                begin
                    mul_start  = 1'b1;
                    mul_a      = pacc_reg;
                    state_next = S_POW_MA;
                end
                else
                begin
                    mul_start  = 1'b1;
                    state_next = S_POW_MB;
                end
            end
            S_POW_MA:
            begin
                if (mul_done)
                begin
                    pacc_next  = mul_res;
                    mul_start  = 1'b1;
                    state_next = S_POW_MB;
                end
            end
            S_POW_MB:
            begin
                if (mul_done)
                begin
                    pbase_next = mul_res;
                    pexp_next  = pexp_reg >> 1;
                    state_next = S_POW;
                end
            end
            // butterflies
            S_BF_RD1:
            begin
                mem_raddr  = j_w[AW-1:0];
                state_next = S_BF_RD2;
            end
            S_BF_RD2:
            begin
                mem_raddr  = jh_w[AW-1:0];
                u_next     = rd_data_reg;
                state_next = S_BF_MUL0;
            end
            S_BF_MUL0:
            begin
                mul_start  = 1'b1;
                mul_a      = w_reg;
                mul_b      = rd_data_reg;
                state_next = S_BF_MUL;
            end
            S_BF_MUL:
            begin
                if (mul_done)
                begin
                    t_next     = mul_res;
                    state_next = S_BF_WR1;
                end
            end
            S_BF_WR1:
            begin
                mem_we     = 1'b1;
                mem_waddr  = j_w[AW-1:0];
                mem_wdata  = bf_add;
                state_next = S_BF_WR2;
            end
            S_BF_WR2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = jh_w[AW-1:0];
                mem_wdata  = bf_sub;
                mul_start  = 1'b1;
                mul_a      = w_reg;
                mul_b      = step_reg;
                state_next = S_BF_TW;
            end
            S_BF_TW:
            begin
                if (mul_done)
                begin
                    if (k_reg + 1'b1 == half_reg)
                    begin
                        k_next   = '0;
                        w_next   = DATA_W'(1);
                        grp_next = grp_step;
                        if (grp_step == n_w)
                        begin
                            half_next  = {half_reg[CW-2:0], 1'b0};
                            stage_next = stage_reg + 1'b1;
                            state_next = S_ST_CHK;
                        end
                        else
                            state_next = S_BF_RD1;
                    end
                    else
                    begin
                        w_next     = mul_res;
                        k_next     = k_reg + 1'b1;
                        state_next = S_BF_RD1;
                    end
                end
            end
            // inverse scaling
            S_SC_RD:
            begin
                if (i_reg == n_w)
                    state_next = S_DONE;
                else
                    state_next = S_SC_MUL;
            end
            S_SC_MUL:
            begin
                mul_start  = 1'b1;
                mul_a      = rd_data_reg;
                mul_b      = scale_reg;
                state_next = S_SC_WAIT;
            end
            S_SC_WAIT:
            begin
                if (mul_done)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = mul_res;
                    i_next     = i_reg + 1'b1;
                    state_next = S_SC_RD;
                end
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
                out_data_next  = '0;
                out_kind_next  = KIND_XFORM;
                state_next     = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        lg_reg       <= lg_next;
        inv_reg      <= inv_next;
        i_reg        <= i_next;
        grp_reg      <= grp_next;
        k_reg        <= k_next;
        half_reg     <= half_next;
        stage_reg    <= stage_next;
        u_reg        <= u_next;
        t_reg        <= t_next;
        w_reg        <= w_next;
        step_reg     <= step_next;
        scale_reg    <= scale_next;
        pbase_reg    <= pbase_next;
        pacc_reg     <= pacc_next;
        pexp_reg     <= pexp_next;
        pscale_reg   <= pscale_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};
    assign m_tuser  = out_kind_reg;

endmodule
`default_nettype wire
